[rtl/core/multi_task_heartbeat_watchdog_core_macros.svh]
// Assertion macros for the heartbeat watchdog core.
// Included by the top level only; no other dependencies.
`ifndef MULTI_TASK_HEARTBEAT_WATCHDOG_CORE_MACROS_SVH
`define MULTI_TASK_HEARTBEAT_WATCHDOG_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MTHW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MTHW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/core/mthw_pkg.sv]
// Shared types and constants for the heartbeat watchdog core.
// No dependencies.
package mthw_pkg;
    localparam int MaxSlots = 16;
    localparam int NumTasks = 64;
    localparam int SlotW    = $clog2(MaxSlots);
    localparam int TaskW    = 6;
    localparam int CountW   = 8;
    localparam int PtrW     = 32;
    localparam int WinW     = 16;
    localparam logic [WinW-1:0] WindowReset = 16'd256;

    localparam logic [1:0] OpBeat     = 2'd0;
    localparam logic [1:0] OpRegister = 2'd1;
    localparam logic [1:0] OpCheck    = 2'd2;

    // Token travelling along the slot chain.
    typedef struct packed {
        logic              reg_req;   // registration still looking for a free slot
        logic              chk_req;   // check walk reaches this slot
        logic [TaskW-1:0]  task_id;
        logic [PtrW-1:0]   base;
    } t_token;

    // Slot view given to the check evaluator.
    typedef struct packed {
        logic              used;
        logic [TaskW-1:0]  task_id;
        logic [PtrW-1:0]   base;
        logic [CountW-1:0] saved;
    } t_slot_view;
endpackage

[rtl/core/mthw_cell.sv]
// One slot cell of the watchdog chain: holds a slot and passes tokens on.
// Depends on mthw_pkg.
module mthw_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mthw_pkg::t_token         i_tok,
    output mthw_pkg::t_token         o_tok,
    input  logic                     i_sel,
    input  logic                     i_save,
    input  logic [mthw_pkg::CountW-1:0] i_save_count,
    output mthw_pkg::t_slot_view     o_view
);
    logic                           r_used;
    logic [mthw_pkg::TaskW-1:0]     r_task;
    logic [mthw_pkg::PtrW-1:0]      r_base;
    logic [mthw_pkg::CountW-1:0]    r_saved;
    logic                           take;

    // A registration is taken by the first free cell it meets.
    assign take = i_tok.reg_req && !r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_task  <= '0;
            r_base  <= '0;
            r_saved <= '0;
        end else begin
            if (take) begin
                r_used <= 1'b1;
                r_task <= i_tok.task_id;
                r_base <= i_tok.base;
            end
            if (i_sel && i_save) begin
                r_saved <= i_save_count;
            end
        end
    end

    always_comb begin
        o_tok = i_tok;
        if (take) begin
            o_tok.reg_req = 1'b0;
        end
    end

    assign o_view = '{used: r_used, task_id: r_task, base: r_base, saved: r_saved};
endmodule

[rtl/core/multi_task_heartbeat_watchdog_core.sv]
// Heartbeat watchdog for up to 16 tasks. A registration is stored in the first
// free slot cell as it is accepted. A heartbeat is accepted, then the task
// counter is updated from its registered read. A check walks the 16 slot cells
// one after another. Each slot passes the read, evaluate and emit states, plus a
// write state when it fails and its task counter is bumped. A flush state closes
// the walk, and no item is accepted until the block is idle again. One failure
// is held back so the final one can carry tlast. A failing slot stalls only
// while a held request and an unread output beat are both waiting. Task
// counters and stack pointers sit in 64-entry memories with one registered read
// port. After reset a clearing pass zeroes them, and no item is accepted
// meanwhile.
// Depends on mthw_pkg, mthw_cell and the macros header.
`include "multi_task_heartbeat_watchdog_core_macros.svh"
module multi_task_heartbeat_watchdog_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // operation[1:0], task_id[7:2], stack_ptr[39:8]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // reset_task[5:0], zero fill
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    localparam int MS = mthw_pkg::MaxSlots;
    localparam int TW = mthw_pkg::TaskW;
    localparam int CW = mthw_pkg::CountW;
    localparam int PW = mthw_pkg::PtrW;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_BEAT, ST_READ, ST_EVAL, ST_WRITE, ST_EMIT, ST_FLUSH
    } t_state;

    t_state                       r_state;
    logic [TW:0]                  r_clr;
    logic [mthw_pkg::WinW-1:0]    r_window;
    logic [mthw_pkg::SlotW:0]     r_slot;
    logic [CW-1:0]                r_cnt;
    logic [PW-1:0]                r_sp;
    logic                         r_fail;
    logic [TW-1:0]                r_beat_task;
    logic                         r_pend_valid;
    logic [TW-1:0]                r_pend_task;
    logic                         r_out_valid;
    logic [TW-1:0]                r_out_task;
    logic                         r_out_last;
    logic [CW-1:0]                mem_cnt [mthw_pkg::NumTasks];
    logic [PW-1:0]                mem_sp  [mthw_pkg::NumTasks];

    mthw_pkg::t_token             tok [MS+1];
    mthw_pkg::t_slot_view         views [MS];
    mthw_pkg::t_slot_view         cur;
    logic [MS-1:0]                sel;
    logic                         acc;
    logic [1:0]                   in_op;
    logic [TW-1:0]                in_task;
    logic [PW-1:0]                in_ptr;
    logic [TW-1:0]                rd_task;
    logic                         pass;
    logic                         walk_done;
    logic                         emit_go;
    logic                         out_free;
    logic [PW:0]                  upper;

    assign in_op   = s_axis_tdata[1:0];
    assign in_task = s_axis_tdata[7:2];
    assign in_ptr  = s_axis_tdata[39:8];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;

    assign tok[0] = '{reg_req: acc && (in_op == mthw_pkg::OpRegister),
                      chk_req: 1'b0, task_id: in_task, base: in_ptr};

    for (genvar g = 0; g < MS; g++) begin : g_cell
        assign sel[g] = (r_slot[mthw_pkg::SlotW-1:0] == (mthw_pkg::SlotW)'(g));
        mthw_cell u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tok(tok[g]), .o_tok(tok[g+1]),
            .i_sel(sel[g] && r_state == ST_EVAL), .i_save(pass && cur.used),
            .i_save_count(r_cnt), .o_view(views[g])
        );
    end

    assign cur   = views[r_slot[mthw_pkg::SlotW-1:0]];
    assign upper = {1'b0, cur.base} + {{(PW+1-mthw_pkg::WinW){1'b0}}, r_window};
    assign pass  = (r_cnt != cur.saved) && (r_sp >= cur.base)
                   && ({1'b0, r_sp} <= upper);
    assign walk_done = (r_slot == (mthw_pkg::SlotW+1)'(MS - 1));
    assign out_free  = !r_out_valid || m_axis_tready;
    assign emit_go   = !r_fail || !r_pend_valid || out_free;

    // The read port follows the incoming heartbeat while idle, else the walked slot.
    assign rd_task = (r_state == ST_IDLE) ? in_task : cur.task_id;

    // Task memories: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            mem_cnt[r_clr[TW-1:0]] <= '0;
            mem_sp[r_clr[TW-1:0]]  <= '0;
        end else if (acc && in_op == mthw_pkg::OpBeat) begin
            mem_sp[in_task] <= in_ptr;
        end else if (r_state == ST_BEAT) begin
            mem_cnt[r_beat_task] <= r_cnt + 1'b1;
        end else if (r_state == ST_WRITE) begin
            mem_cnt[cur.task_id] <= r_cnt + 1'b1;
        end
        r_cnt <= mem_cnt[rd_task];
        r_sp  <= mem_sp[rd_task];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_window     <= mthw_pkg::WindowReset;
            r_slot       <= '0;
            r_fail       <= 1'b0;
            r_beat_task  <= '0;
            r_pend_valid <= 1'b0;
            r_pend_task  <= '0;
            r_out_valid  <= 1'b0;
            r_out_task   <= '0;
            r_out_last   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr[TW-1:0] == TW'(mthw_pkg::NumTasks - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (acc && in_op == mthw_pkg::OpCheck) begin
                        r_slot  <= '0;
                        r_state <= ST_READ;
                    end else if (acc && in_op == mthw_pkg::OpBeat) begin
                        r_beat_task <= in_task;
                        r_state     <= ST_BEAT;
                    end
                end
                ST_BEAT: begin
                    r_state <= ST_IDLE;
                end
                ST_READ: begin
                    r_state <= ST_EVAL;
                end
                ST_EVAL: begin
                    r_fail <= cur.used && !pass;
                    if (!cur.used || pass) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    // Hold one failure back so the final one can carry tlast.
                    if (emit_go) begin
                        if (r_fail) begin
                            if (r_pend_valid) begin
                                r_out_valid <= 1'b1;
                                r_out_task  <= r_pend_task;
                                r_out_last  <= 1'b0;
                            end
                            r_pend_valid <= 1'b1;
                            r_pend_task  <= cur.task_id;
                        end
                        if (walk_done) begin
                            r_state <= ST_FLUSH;
                        end else begin
                            r_slot  <= r_slot + 1'b1;
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!r_pend_valid) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_task   <= r_pend_task;
                        r_out_last   <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_task};
    assign m_axis_tlast  = r_out_last;

    `MTHW_ASSERT(a_no_accept_busy, i_clk, i_rst_n, (r_state != ST_IDLE) |-> !s_axis_tready, "accepted while busy")
    `MTHW_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "output beat dropped")
    `MTHW_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")
endmodule

[bench/tb_multi_task_heartbeat_watchdog_core.sv]
// Self-checking bench for the heartbeat watchdog core: directed table, then random items.
// Uses mthw_pkg for the operation codes and table sizes; needs only the RTL.
module tb_multi_task_heartbeat_watchdog_core;

    localparam int CycleLimit = 300000;
    localparam int DrainWait  = 40;

    typedef struct {
        logic [1:0]  op;
        logic [5:0]  tid;
        logic [31:0] ptr;
        bit          typed;
        logic [5:0]  typed_task;
    } t_row;

    typedef struct {
        logic [5:0] task_id;
        logic       last;
    } t_reset_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    multi_task_heartbeat_watchdog_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the watchdog tables.
    logic [15:0] window;
    bit          used_q [mthw_pkg::MaxSlots];
    logic [5:0]  owner_q [mthw_pkg::MaxSlots];
    logic [31:0] base_q [mthw_pkg::MaxSlots];
    logic [7:0]  saved_q [mthw_pkg::MaxSlots];
    logic [7:0]  beats_q [mthw_pkg::NumTasks];
    logic [31:0] sp_q [mthw_pkg::NumTasks];

    t_reset_req  pending_resets[$];
    t_reset_req  found[$];
    int          mismatches = 0;
    int          n_items = 0, n_resets = 0, n_checks = 0;
    int          cycles = 0;
    int          rx_stall = 0;
    bit          got_beat = 1'b0;
    bit          calm = 1'b0;

    // Applies one item to the shadow tables and leaves the reset requests it causes in found.
    function automatic void predict_watchdog(input logic [1:0] op, input logic [5:0] tid,
                                             input logic [31:0] ptr);
        logic [32:0] top;
        bit          ok;
        found.delete();
        if (op == mthw_pkg::OpBeat) begin
            beats_q[tid] = beats_q[tid] + 8'd1;
            sp_q[tid] = ptr;
        end else if (op == mthw_pkg::OpRegister) begin
            for (int s = 0; s < mthw_pkg::MaxSlots; s++) begin
                if (!used_q[s]) begin
                    used_q[s] = 1'b1;
                    owner_q[s] = tid;
                    base_q[s] = ptr;
                    break;
                end
            end
        end else if (op == mthw_pkg::OpCheck) begin
            for (int s = 0; s < mthw_pkg::MaxSlots; s++) begin
                if (used_q[s]) begin
                    top = {1'b0, base_q[s]} + {17'd0, window};
                    ok = (beats_q[owner_q[s]] != saved_q[s]) && (sp_q[owner_q[s]] >= base_q[s])
                         && ({1'b0, sp_q[owner_q[s]]} <= top);
                    if (ok) begin
                        saved_q[s] = beats_q[owner_q[s]];
                    end else begin
                        beats_q[owner_q[s]] = beats_q[owner_q[s]] + 8'd1;
                        found.push_back('{owner_q[s], 1'b0});
                    end
                end
            end
            if (found.size() > 0) found[found.size()-1].last = 1'b1;
        end
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [5:0] tid,
                             input logic [31:0] ptr, input bit typed, input logic [5:0] ttask);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {ptr, tid, op};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        predict_watchdog(op, tid, ptr);
        if (typed) begin
            // The typed row carries the single expected request.
            pending_resets.push_back('{ttask, 1'b1});
        end else begin
            foreach (found[k]) pending_resets.push_back(found[k]);
        end
        n_items++;
        if (op == mthw_pkg::OpCheck) n_checks++;
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_resets.size() > 0 || !s_axis_tready) @(negedge i_clk);
        repeat (DrainWait) @(negedge i_clk);
    endtask

    task automatic write_window(input logic [15:0] value);
        settle();
        i_cfg_we = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        window = value;
    endtask

    // Result side: a new stall is drawn after every accepted beat.
    always @(negedge i_clk) begin
        int left;
        if (got_beat) begin
            left = calm ? 0 : $urandom_range(0, 4);
        end else begin
            left = rx_stall;
        end
        if (left > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall <= left - 1;
        end else begin
            m_axis_tready <= i_rst_n;
            rx_stall <= 0;
        end
    end

    // Comparison against the oldest expectation.
    always @(posedge i_clk) begin
        t_reset_req want;
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
        got_beat <= m_axis_tvalid && m_axis_tready;
        if (m_axis_tvalid && m_axis_tready) begin
            n_resets <= n_resets + 1;
            if (pending_resets.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected reset beat task=%0d last=%0b",
                             m_axis_tdata[5:0], m_axis_tlast);
            end else begin
                want = pending_resets.pop_front();
                if (m_axis_tdata !== {2'b00, want.task_id} || m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("reset beat mismatch: expected task=%0d last=%0b, got %0d/%0b",
                                 want.task_id, want.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    t_row rows[$];
    int   watched[$];

    initial begin
        logic [1:0]  op;
        logic [5:0]  tid;
        logic [31:0] ptr;
        int          pick, slot_pick;

        window = mthw_pkg::WindowReset;
        for (int s = 0; s < mthw_pkg::MaxSlots; s++) begin
            used_q[s] = 0; owner_q[s] = '0; base_q[s] = '0; saved_q[s] = '0;
        end
        for (int t = 0; t < mthw_pkg::NumTasks; t++) begin
            beats_q[t] = '0; sp_q[t] = '0;
        end

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // A fresh slot keeps saved count zero, so its first check fails at once.
        rows.push_back('{mthw_pkg::OpRegister, 6'd5, 32'd0, 0, 0});
        rows.push_back('{mthw_pkg::OpCheck, 6'd0, 32'd0, 1, 6'd5});
        rows.push_back('{mthw_pkg::OpCheck, 6'd0, 32'd0, 0, 0});
        rows.push_back('{mthw_pkg::OpBeat, 6'd5, 32'd256, 0, 0});
        rows.push_back('{mthw_pkg::OpCheck, 6'd0, 32'd0, 0, 0});
        rows.push_back('{mthw_pkg::OpBeat, 6'd5, 32'd257, 0, 0});
        rows.push_back('{mthw_pkg::OpCheck, 6'd0, 32'd0, 1, 6'd5});
        rows.push_back('{mthw_pkg::OpRegister, 6'd63, 32'hFFFF_FFFF, 0, 0});
        rows.push_back('{mthw_pkg::OpBeat, 6'd63, 32'hFFFF_FFFF, 0, 0});
        rows.push_back('{mthw_pkg::OpBeat, 6'd5, 32'd100, 0, 0});
        rows.push_back('{mthw_pkg::OpCheck, 6'd0, 32'd0, 0, 0});
        rows.push_back('{mthw_pkg::OpRegister, 6'd5, 32'd100, 0, 0});
        rows.push_back('{2'd3, 6'd63, 32'hFFFF_FFFF, 0, 0});
        rows.push_back('{mthw_pkg::OpBeat, 6'd0, 32'd0, 0, 0});
        rows.push_back('{mthw_pkg::OpBeat, 6'd5, 32'd99, 0, 0});
        rows.push_back('{mthw_pkg::OpCheck, 6'd0, 32'd0, 0, 0});
        rows.push_back('{mthw_pkg::OpCheck, 6'd0, 32'd0, 0, 0});
        foreach (rows[r]) send_item(rows[r].op, rows[r].tid, rows[r].ptr,
                                    rows[r].typed, rows[r].typed_task);
        watched.push_back(5);
        watched.push_back(63);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: write_window(16'hFFFF);
                2: write_window(16'd1);
                3: write_window(16'($urandom_range(2, 4000)));
                4: write_window(mthw_pkg::WindowReset);
                default: ;
            endcase
            calm = (phase == 2);
            for (int i = 0; i < 54; i++) begin
                pick = $urandom_range(0, 99);
                tid = 6'($urandom);
                ptr = $urandom;
                if (pick < 45) begin
                    op = mthw_pkg::OpBeat;
                    if (watched.size() > 0 && pick < 40) begin
                        slot_pick = $urandom_range(0, mthw_pkg::MaxSlots - 1);
                        if (used_q[slot_pick]) begin
                            tid = owner_q[slot_pick];
                            ptr = base_q[slot_pick] + $urandom_range(0, window + 2) - 1;
                        end else begin
                            tid = 6'(watched[$urandom_range(0, watched.size() - 1)]);
                        end
                    end
                end else if (pick < 60) begin
                    op = mthw_pkg::OpRegister;
                    if (pick < 50) ptr = $urandom_range(0, 300);
                    watched.push_back(int'(tid));
                end else if (pick < 95) begin
                    op = mthw_pkg::OpCheck;
                end else begin
                    op = 2'd3;
                end
                send_item(op, tid, ptr, 0, 0);
            end
            // Let every request of the phase drain before the next burst starts.
            settle();
        end

        $display("covered %0d items with %0d checks and %0d reset beats over five windows",
                 n_items, n_checks, n_resets);
        if (mismatches == 0 && pending_resets.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d requests never seen", mismatches,
                     pending_resets.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule
